/* hw/rtl/brfps_pkg.sv */
// Shared types and constants for the byte ring FIFO with peek and skip.
package brfps_pkg;

  localparam int PTR_W = 10;  // pointers run modulo 2*capacity, capacity <= 511
  localparam int CAP_W = 9;

  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_SKIP  = 3'd2;
  localparam logic [2:0] KIND_PEEK  = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;
  localparam logic [2:0] KIND_RESET = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] write_data;
    logic [8:0] skip_count;
    logic [7:0] peek_offset;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ok;
    logic [8:0] skipped;
    logic [8:0] fill_level;
    logic [8:0] free_space;
  } out_t;

  typedef struct packed {
    logic exec;  // perform the accepted operation this cycle
  } cmd_t;

endpackage

/* hw/rtl/byte_ring_fifo_peek_skip.sv */
// Byte ring FIFO with read, write, skip, peek, clear and pointer reset.
// Latency: the result beat is valid in the cycle after the input beat is accepted.
// Throughput: no new beat is taken before the last result is taken; one operation is in
// flight at a time, since the controller takes no beat while a result is held.
// Reset (rst, synchronous): pointers cleared, capacity = min(256, DEPTH);
// the byte store is not cleared.
module byte_ring_fifo_peek_skip #(
  parameter int DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [8:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  brfps_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output brfps_pkg::out_t  out_data
);
  import brfps_pkg::*;

  cmd_t cmd;

  brfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  brfps_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .in_data     (in_data),
    .out_data    (out_data)
  );

endmodule

/* hw/rtl/brfps_ctrl.sv */
// Controller: accepts one beat, then holds the result until it is taken.
module brfps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output brfps_pkg::cmd_t    cmd
);
  import brfps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_RESP);
  assign cmd.exec  = (state == ST_IDLE) && in_valid;

endmodule

/* hw/rtl/brfps_dp.sv */
// Datapath: pointers, slot indices, capacity register, byte store and result.
module brfps_dp #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [8:0]        cfg_wr_data,
  input  brfps_pkg::cmd_t   cmd,
  input  brfps_pkg::in_t    in_data,
  output brfps_pkg::out_t   out_data
);
  import brfps_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [CAP_W-1:0] CAP_TOP = (DEPTH > 511) ? 9'd511 : CAP_W'(DEPTH);
  localparam logic [CAP_W-1:0] CAP_RST = (DEPTH < 256) ? CAP_W'(DEPTH) : 9'd256;

  logic [CAP_W-1:0] cap;
  logic [PTR_W-1:0] wp, rp, wp_next, rp_next;
  logic [CAP_W-1:0] wslot, rslot, wslot_next, rslot_next;
  logic             ok, ok_next;
  logic             rd_sel, rd_sel_next;
  logic [8:0]       skipped, skipped_next;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       mem_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    waddr, raddr;

  logic [PTR_W-1:0] span;
  logic [PTR_W-1:0] lvl;
  logic [CAP_W-1:0] cfg_cap;
  logic [8:0]       skip_n;
  logic [PTR_W:0]   ptr_sum;
  logic [CAP_W:0]   slot_sum, peek_sum;
  logic [CAP_W-1:0] peek_slot;

  function automatic logic [PTR_W-1:0] level_of(input logic [PTR_W-1:0] w,
                                                input logic [PTR_W-1:0] r,
                                                input logic [PTR_W-1:0] s);
    if (w >= r) return w - r;
    else        return s - r + w;
  endfunction

  assign span = {cap, 1'b0};
  assign lvl  = level_of(wp, rp, span);

  always_comb begin
    cfg_cap = cfg_wr_data;
    if (cfg_cap == '0) cfg_cap = 9'd1;
    if (cfg_cap > CAP_TOP) cfg_cap = CAP_TOP;
  end

  // skip amount clamped to level; sums stay below twice the modulus
  always_comb begin
    skip_n    = ({1'b0, in_data.skip_count} > lvl) ? lvl[8:0] : in_data.skip_count;
    ptr_sum   = {1'b0, rp} + {2'b00, skip_n};
    slot_sum  = {1'b0, rslot} + {1'b0, skip_n};
    peek_sum  = {1'b0, rslot} + {2'b00, in_data.peek_offset};
    peek_slot = (peek_sum >= {1'b0, cap}) ? CAP_W'(peek_sum - {1'b0, cap})
                                          : peek_sum[CAP_W-1:0];
  end

  always_comb begin
    wp_next      = wp;
    rp_next      = rp;
    wslot_next   = wslot;
    rslot_next   = rslot;
    ok_next      = ok;
    rd_sel_next  = rd_sel;
    skipped_next = skipped;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    waddr        = AW'(wslot);
    raddr        = AW'(rslot);
    if (cmd.exec) begin
      ok_next      = 1'b0;
      rd_sel_next  = 1'b0;
      skipped_next = '0;
      case (in_data.kind)
        KIND_WRITE: begin
          if (lvl < {1'b0, cap}) begin
            mem_we     = 1'b1;
            wp_next    = (wp + 1'b1 == span) ? '0 : wp + 1'b1;
            wslot_next = (wslot + 1'b1 == cap) ? '0 : wslot + 1'b1;
            ok_next    = 1'b1;
          end
        end
        KIND_READ: begin
          if (lvl != '0) begin
            mem_re      = 1'b1;
            rp_next     = (rp + 1'b1 == span) ? '0 : rp + 1'b1;
            rslot_next  = (rslot + 1'b1 == cap) ? '0 : rslot + 1'b1;
            ok_next     = 1'b1;
            rd_sel_next = 1'b1;
          end
        end
        KIND_SKIP: begin
          skipped_next = skip_n;
          rp_next    = (ptr_sum >= {1'b0, span}) ? PTR_W'(ptr_sum - {1'b0, span})
                                                 : ptr_sum[PTR_W-1:0];
          rslot_next = (slot_sum >= {1'b0, cap}) ? CAP_W'(slot_sum - {1'b0, cap})
                                                 : slot_sum[CAP_W-1:0];
        end
        KIND_PEEK: begin
          if ({2'b00, in_data.peek_offset} < lvl) begin
            mem_re      = 1'b1;
            raddr       = AW'(peek_slot);
            ok_next     = 1'b1;
            rd_sel_next = 1'b1;
          end
        end
        KIND_CLEAR: begin
          rp_next    = wp;
          rslot_next = wslot;
        end
        KIND_RESET: begin
          wp_next    = '0;
          rp_next    = '0;
          wslot_next = '0;
          rslot_next = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap     <= CAP_RST;
      wp      <= '0;
      rp      <= '0;
      wslot   <= '0;
      rslot   <= '0;
      ok      <= 1'b0;
      rd_sel  <= 1'b0;
      skipped <= '0;
    end else if (cfg_wr_en) begin
      cap     <= cfg_cap;
      wp      <= '0;
      rp      <= '0;
      wslot   <= '0;
      rslot   <= '0;
    end else begin
      wp      <= wp_next;
      rp      <= rp_next;
      wslot   <= wslot_next;
      rslot   <= rslot_next;
      ok      <= ok_next;
      rd_sel  <= rd_sel_next;
      skipped <= skipped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= in_data.write_data;
    if (mem_re) mem_q <= mem[raddr];
  end

  // result fields follow the updated pointers, held while the beat waits
  assign out_data.read_data  = rd_sel ? mem_q : 8'd0;
  assign out_data.ok         = ok;
  assign out_data.skipped    = skipped;
  assign out_data.fill_level = lvl[8:0];
  assign out_data.free_space = cap - lvl[8:0];

endmodule

/* hw/rtl/brfps_checker.sv */
// Port-level checker for the byte ring FIFO, bound to the top level.
module brfps_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input brfps_pkg::in_t   in_data,
  input logic             out_valid,
  input logic             out_stall,
  input brfps_pkg::out_t  out_data
);
  import brfps_pkg::*;

  // one operation in flight: no input beat taken while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // every accepted beat yields a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no result after accepted beat");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input beat changed");

  // failed or non-data operations return zero data and never skip and succeed at once
  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.ok || (out_data.read_data == 8'd0)) &&
                   !(out_data.ok && (out_data.skipped != 9'd0))))
    else $error("inconsistent result fields");

endmodule

bind byte_ring_fifo_peek_skip brfps_checker u_brfps_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
